// ----- rtl/sgdm_pkg.sv -----
// Shared constants, codes and types for the SGD momentum update unit.
// No dependencies; imported by every module of the block.
package sgdm_pkg;

	localparam int DEF_NUM_PARAMS = 1024;
	localparam int DEF_VALUE_BITS = 32;

	localparam int IDX_BITS     = 10;
	localparam int DATA_BITS    = 32;
	localparam int COEF_BITS    = 16;
	localparam int CFG_IDX_BITS = 2;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_UPDATE = 1'b1;

	localparam logic [CFG_IDX_BITS-1:0] CFG_MOMENTUM = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_NESTEROV = 2'd2;

	typedef struct packed {
		logic                        sat;
		logic signed [DATA_BITS-1:0] val;
	} sat_val_t;

endpackage

// ----- rtl/sgdm_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on sgdm_pkg for its default depth and width.
module sgdm_ram
	import sgdm_pkg::*;
#(
	parameter int DEPTH     = DEF_NUM_PARAMS,
	parameter int WIDTH     = DATA_BITS,
	parameter int ADDR_BITS = 10
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	assign rdata = rd_data_q;

endmodule

// ----- rtl/sgd_momentum_update_unit.sv -----
// SGD momentum update unit: configuration registers, four-stage update pipeline.
// Depends on sgdm_pkg and sgdm_ram (parameter store and momentum store).
//
// Usage
//   Input channel (in_valid/in_stall): one item per transfer. A load item
//   (req_type 0) writes a parameter and clears its momentum; an update item
//   (req_type 1) applies one gradient element at the given learning rate.
//   Output channel (out_valid/out_stall): one result per item, in order,
//   carrying the index, the new parameter value and a saturation flag.
//   Configuration (cfg_valid/cfg_ready): always ready; write only while idle.
//   A result is registered through stages s1 to s4 and then the output
//   register. Throughput: one item per cycle while in_stall is low. An
//   in-range update whose index matches an item still in the four pipeline
//   stages is held with in_stall until that item has written back, since
//   each store is read at the input transfer and written only as the item
//   leaves the last stage.
//   When the receiver stalls, the result waits in the output register;
//   empty stages still advance, so up to four more items are taken.
//   Reset clears the configuration registers and the pipeline valids; both
//   stores keep their contents and are undefined until written.
module sgd_momentum_update_unit
	import sgdm_pkg::*;
#(
	parameter int NUM_PARAMS = DEF_NUM_PARAMS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        req_type,
	input  logic [IDX_BITS-1:0]         elem_index,
	input  logic signed [DATA_BITS-1:0] data_value,
	input  logic [COEF_BITS-1:0]        learn_rate,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [IDX_BITS-1:0]         out_index,
	output logic signed [DATA_BITS-1:0] new_param,
	output logic                        saturated,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [COEF_BITS-1:0]        cfg_data
);

	localparam int SAT_BITS  = (VALUE_BITS < 16) ? 16 : ((VALUE_BITS > 32) ? 32 : VALUE_BITS);
	localparam int DEPTH     = (NUM_PARAMS < 1) ? 1 : NUM_PARAMS;
	localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic signed [39:0] SAT_HI = 40'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
	localparam logic signed [39:0] SAT_LO = -SAT_HI - 40'sd1;

	function automatic sat_val_t clamp_val(input logic signed [39:0] x);
		sat_val_t r;
		if (x > SAT_HI) begin
			r.sat = 1'b1;
			r.val = 32'(SAT_HI);
		end else if (x < SAT_LO) begin
			r.sat = 1'b1;
			r.val = 32'(SAT_LO);
		end else begin
			r.sat = 1'b0;
			r.val = 32'(x);
		end
		return r;
	endfunction

	function automatic logic signed [39:0] round40(input logic signed [51:0] x);
		logic signed [51:0] t;
		t = x + 52'sd32768;
		return 40'(t >>> 16);
	endfunction

	// configuration
	logic [COEF_BITS-1:0] mu_q;
	logic [COEF_BITS-1:0] decay_q;
	logic                 nest_q;
	logic                 mom_en;

	assign cfg_ready = 1'b1;
	assign mom_en    = (mu_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q    <= '0;
			decay_q <= '0;
			nest_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MOMENTUM: mu_q    <= cfg_data;
				CFG_DECAY:    decay_q <= cfg_data;
				CFG_NESTEROV: nest_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic                        vld_s1, vld_s2, vld_s3, vld_s4;
	logic                        type_s1, type_s2, type_s3, type_s4;
	logic                        inr_s1, inr_s2, inr_s3, inr_s4;
	logic [IDX_BITS-1:0]         idx_s1, idx_s2, idx_s3, idx_s4;
	logic signed [DATA_BITS-1:0] data_s1, data_s2, data_s3, data_s4;
	logic                        adv;
	logic                        hazard;
	logic                        accept;
	logic                        in_range;
	logic [31:0]                 idx_ext;
	logic                        out_valid_q;

	assign idx_ext  = 32'(elem_index);
	assign in_range = (idx_ext < 32'(DEPTH));
	assign adv      = !vld_s4 || !out_valid_q || !out_stall;
	assign hazard   = (req_type == REQ_UPDATE) && in_range && (
		(vld_s1 && idx_s1 == elem_index) || (vld_s2 && idx_s2 == elem_index) ||
		(vld_s3 && idx_s3 == elem_index) || (vld_s4 && idx_s4 == elem_index));
	assign in_stall = !adv || hazard;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stores
	logic [SAT_BITS-1:0]  p_rd, m_rd, p_wd, m_wd;
	logic                 p_re, m_re, p_we, m_we;
	logic [ADDR_BITS-1:0] raddr, waddr;
	logic [31:0]          widx_ext;

	assign raddr    = idx_ext[ADDR_BITS-1:0];
	assign widx_ext = 32'(idx_s4);
	assign waddr    = widx_ext[ADDR_BITS-1:0];
	assign p_re     = accept && in_range && (req_type == REQ_UPDATE);
	assign m_re     = p_re && mom_en;

	sgdm_ram #(
		.DEPTH     (DEPTH),
		.WIDTH     (SAT_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_param_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (waddr),
		.wdata (p_wd),
		.re    (p_re),
		.raddr (raddr),
		.rdata (p_rd)
	);

	sgdm_ram #(
		.DEPTH     (DEPTH),
		.WIDTH     (SAT_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_mom_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (waddr),
		.wdata (m_wd),
		.re    (m_re),
		.raddr (raddr),
		.rdata (m_rd)
	);

	// stage 1: decayed rate, store read
	logic [COEF_BITS-1:0] lr_s1, ld_s1;
	logic [31:0]          ld_full;

	assign ld_full = 32'(learn_rate) * 32'(decay_q) + 32'd32768;

	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1 <= req_type;
			idx_s1  <= elem_index;
			inr_s1  <= in_range;
			data_s1 <= data_value;
			lr_s1   <= learn_rate;
			ld_s1   <= ld_full[31:16];
		end
	end

	// stage 1 to 2: products
	logic signed [DATA_BITS-1:0] p_ext, m_ext;
	logic signed [48:0]          lrg_c, ldp_c, mm_c;
	logic signed [DATA_BITS-1:0] p_s2, p_s3, p_s4;
	logic signed [48:0]          lrg_s2, ldp_s2, mm_s2;

	assign p_ext = 32'($signed(p_rd));
	assign m_ext = 32'($signed(m_rd));
	assign lrg_c = 49'($signed({1'b0, lr_s1})) * 49'(data_s1);
	assign ldp_c = 49'($signed({1'b0, ld_s1})) * 49'(p_ext);
	assign mm_c  = mom_en ? 49'($signed({1'b0, mu_q})) * 49'(m_ext) : '0;

	always_ff @(posedge clk) begin
		if (adv) begin
			type_s2 <= type_s1;
			idx_s2  <= idx_s1;
			inr_s2  <= inr_s1;
			data_s2 <= data_s1;
			p_s2    <= p_ext;
			lrg_s2  <= lrg_c;
			ldp_s2  <= ldp_c;
			mm_s2   <= mm_c;
		end
	end

	// stage 2 to 3: velocity
	logic signed [49:0]          step_c, step_s3, step_s4;
	logic signed [51:0]          acc_c;
	sat_val_t                    v_c;
	logic signed [DATA_BITS-1:0] v_s3, v_s4;
	logic                        vsat_s3, vsat_s4;

	assign step_c = 50'(lrg_s2) + 50'(ldp_s2);
	assign acc_c  = 52'(mm_s2) - 52'(step_c);
	assign v_c    = clamp_val(round40(acc_c));

	always_ff @(posedge clk) begin
		if (adv) begin
			type_s3 <= type_s2;
			idx_s3  <= idx_s2;
			inr_s3  <= inr_s2;
			data_s3 <= data_s2;
			p_s3    <= p_s2;
			step_s3 <= step_c;
			v_s3    <= v_c.val;
			vsat_s3 <= (type_s2 == REQ_UPDATE) && v_c.sat;
		end
	end

	// stage 3 to 4: look-ahead product
	logic signed [48:0] muv_c, muv_s4;

	assign muv_c = 49'($signed({1'b0, mu_q})) * 49'(v_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			type_s4 <= type_s3;
			idx_s4  <= idx_s3;
			inr_s4  <= inr_s3;
			data_s4 <= data_s3;
			p_s4    <= p_s3;
			step_s4 <= step_s3;
			v_s4    <= v_s3;
			vsat_s4 <= vsat_s3;
			muv_s4  <= muv_c;
		end
	end

	// stage 4: new parameter, write back
	logic signed [51:0] nes_c;
	sat_val_t           nes_r, plain_r, load_r, res_c;
	logic               res_sat;

	assign nes_c   = (52'(p_s4) <<< 16) + 52'(muv_s4) - 52'(step_s4);
	assign nes_r   = clamp_val(round40(nes_c));
	assign plain_r = clamp_val(40'(p_s4) + 40'(v_s4));
	assign load_r  = clamp_val(40'(data_s4));

	always_comb begin
		res_c   = '0;
		res_sat = 1'b0;
		if (inr_s4) begin
			if (type_s4 == REQ_LOAD) begin
				res_c   = load_r;
				res_sat = load_r.sat;
			end else if (nest_q) begin
				res_c   = nes_r;
				res_sat = vsat_s4 || nes_r.sat;
			end else begin
				res_c   = plain_r;
				res_sat = vsat_s4 || plain_r.sat;
			end
		end
	end

	assign p_we = vld_s4 && adv && inr_s4;
	assign m_we = p_we && ((type_s4 == REQ_LOAD) || mom_en);
	assign p_wd = res_c.val[SAT_BITS-1:0];
	assign m_wd = (type_s4 == REQ_LOAD) ? '0 : v_s4[SAT_BITS-1:0];

	// output register
	logic [IDX_BITS-1:0]         out_index_q;
	logic signed [DATA_BITS-1:0] new_param_q;
	logic                        saturated_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (vld_s4 && adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s4 && adv) begin
			out_index_q <= idx_s4;
			new_param_q <= res_c.val;
			saturated_q <= res_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign new_param = new_param_q;
	assign saturated = saturated_q;

endmodule

// ----- rtl/sgdm_checker.sv -----
// Port-level checks for the SGD momentum update unit, bound to the top level.
// Depends on sgdm_pkg and on the port list of sgd_momentum_update_unit.
module sgdm_checker
	import sgdm_pkg::*;
#(
	parameter int NUM_PARAMS = DEF_NUM_PARAMS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [IDX_BITS-1:0]         out_index,
	input logic signed [DATA_BITS-1:0] new_param,
	input logic                        saturated,
	input logic                        cfg_valid,
	input logic                        cfg_ready
);

	localparam int SAT_BITS = (VALUE_BITS < 16) ? 16 : ((VALUE_BITS > 32) ? 32 : VALUE_BITS);
	localparam logic signed [DATA_BITS-1:0] OUT_HI = 32'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
	localparam logic signed [DATA_BITS-1:0] OUT_LO = -OUT_HI - 32'sd1;

	logic out_of_range;

	assign out_of_range = (32'(out_index) >= 32'(NUM_PARAMS));

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_index) &&
			$stable(new_param) && $stable(saturated))
		else $error("result changed while stalled");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> (new_param == '0) && !saturated)
		else $error("out-of-range index gave a nonzero result");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (new_param <= OUT_HI) && (new_param >= OUT_LO))
		else $error("result outside saturation range");

endmodule

bind sgd_momentum_update_unit sgdm_checker #(
	.NUM_PARAMS (NUM_PARAMS),
	.VALUE_BITS (VALUE_BITS)
) u_sgdm_checker (.*);
